### hw/rtl/b64e_pkg.sv
`default_nettype none
package b64e_pkg;

	// Padding carried by one queued group.
	typedef enum logic [1:0] {
		PAD_NONE = 2'd0,
		PAD_ONE  = 2'd1,
		PAD_TWO  = 2'd2
	} b64e_pad_t;

	// One group of work handed from the front end to the character emitter.
	typedef struct packed {
		logic [23:0] group;
		b64e_pad_t   pad;
		logic        newline;
		logic        fin;
	} b64e_job_t;

	localparam int unsigned QUEUE_DEPTH = 2;
	localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

	localparam logic [6:0] CHAR_PAD     = 7'h3D;
	localparam logic [6:0] CHAR_NEWLINE = 7'h0A;

	localparam logic [2:0] SLOT_NEWLINE = 3'd4;

	// Map a sextet onto the standard alphabet with '+' and '/'.
	function automatic logic [6:0] b64e_symbol(input logic [5:0] v);
		logic [6:0] r;
		if (v < 6'd26) begin
			r = 7'h41 + {1'b0, v};
		end else if (v < 6'd52) begin
			r = 7'h61 + {1'b0, v} - 7'd26;
		end else if (v < 6'd62) begin
			r = 7'h30 + {1'b0, v} - 7'd52;
		end else if (v == 6'd62) begin
			r = 7'h2B;
		end else begin
			r = 7'h2F;
		end
		return r;
	endfunction

endpackage
`default_nettype wire

### hw/rtl/b64e_if.sv
`default_nettype none
// Byte channel into the encoder.
interface b64e_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       final_byte;

	modport source (output valid, output data_byte, output final_byte, input ready);
	modport sink   (input valid, input data_byte, input final_byte, output ready);
endinterface

// Character channel out of the encoder.
interface b64e_char_if;
	logic       valid;
	logic       ready;
	logic [6:0] out_char;
	logic       run_last;
	logic       stream_end;

	modport source (output valid, output out_char, output run_last, output stream_end,
		input ready);
	modport sink   (input valid, input out_char, input run_last, input stream_end,
		output ready);
endinterface
`default_nettype wire

### hw/rtl/base64_stream_encoder.sv
// Path: a byte that closes a group goes into the queue; its first character then goes to the
// output register. Throughput: one character per cycle while the sink is ready; a group gives
// four or five characters, so steady input is limited by the single character output register.
// Bytes that only fill the group are taken every cycle while the two-entry queue has room.
// Reset: arst_n is asynchronous and active low; it clears the held bytes, line counter,
// queue, output register and sets the line limit to zero (no wrapping).
`default_nettype none
module base64_stream_encoder (
	input  wire            clk,
	input  wire            arst_n,
	input  wire            cfg_we,
	input  wire  [9:0]     cfg_wdata,
	b64e_byte_if.sink      bytes,
	b64e_char_if.source    chars
);
	import b64e_pkg::*;

	logic      queue_full;
	logic      push;
	b64e_job_t push_job;
	logic      pop;
	logic      head_valid;
	b64e_job_t head_job;

	// Front end: holds bytes, tracks the line and forms groups.
	b64e_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (bytes.valid),
		.in_byte    (bytes.data_byte),
		.in_final   (bytes.final_byte),
		.in_ready   (bytes.ready),
		.queue_full (queue_full),
		.push       (push),
		.push_job   (push_job)
	);

	// Short queue between the two halves.
	b64e_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_job   (push_job),
		.full       (queue_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_job   (head_job)
	);

	// Back end: emits one character per transaction.
	b64e_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.head_valid     (head_valid),
		.head_job       (head_job),
		.pop            (pop),
		.out_valid      (chars.valid),
		.out_ready      (chars.ready),
		.out_char       (chars.out_char),
		.out_run_last   (chars.run_last),
		.out_stream_end (chars.stream_end)
	);
endmodule
`default_nettype wire

### hw/rtl/b64e_front.sv
`default_nettype none
module b64e_front (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               cfg_we,
	input  wire  [9:0]        cfg_wdata,
	input  wire               in_valid,
	input  wire  [7:0]        in_byte,
	input  wire               in_final,
	output logic              in_ready,
	input  wire               queue_full,
	output logic              push,
	output b64e_pkg::b64e_job_t push_job
);
	import b64e_pkg::*;

	logic [9:0]  line_limit_q;
	logic [15:0] held_q;
	logic [1:0]  held_cnt_q;
	logic [10:0] line_cnt_q;

	logic        accept;
	logic        full_group;
	logic [10:0] line_sum;
	logic        wrap;

	// A byte is taken whenever the queue has room for the group it may close.
	assign in_ready   = !queue_full;
	assign accept     = in_valid && in_ready;
	assign full_group = (held_cnt_q == 2'd2);

	// Line counter advances by four per full group and wraps on the limit.
	assign line_sum = line_cnt_q + 11'd4;
	assign wrap     = (line_limit_q != 10'd0) && (line_sum >= {1'b0, line_limit_q});

	// Classify the byte: held, full group, or padded tail.
	always_comb begin
		push             = 1'b0;
		push_job.group   = {held_q, in_byte};
		push_job.pad     = PAD_NONE;
		push_job.newline = 1'b0;
		push_job.fin     = in_final;
		if (accept) begin
			if (full_group) begin
				push             = 1'b1;
				push_job.newline = wrap;
			end else if (in_final) begin
				push = 1'b1;
				if (held_cnt_q == 2'd1) begin
					push_job.group = {held_q[7:0], in_byte, 8'h00};
					push_job.pad   = PAD_ONE;
				end else begin
					push_job.group = {in_byte, 16'h0000};
					push_job.pad   = PAD_TWO;
				end
			end
		end
	end

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_limit_q <= 10'd0;
		end else if (cfg_we) begin
			line_limit_q <= cfg_wdata;
		end
	end

	// Held bytes and line position.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q     <= 16'h0000;
			held_cnt_q <= 2'd0;
			line_cnt_q <= 11'd0;
		end else if (accept) begin
			if (full_group || in_final) begin
				held_q     <= 16'h0000;
				held_cnt_q <= 2'd0;
				if (in_final) begin
					line_cnt_q <= 11'd0;
				end else begin
					line_cnt_q <= wrap ? 11'd0 : line_sum;
				end
			end else begin
				held_q     <= {held_q[7:0], in_byte};
				held_cnt_q <= held_cnt_q + 2'd1;
			end
		end
	end
endmodule
`default_nettype wire

### hw/rtl/b64e_queue.sv
`default_nettype none
module b64e_queue (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                push,
	input  wire b64e_pkg::b64e_job_t push_job,
	output logic               full,
	input  wire                pop,
	output logic               head_valid,
	output b64e_pkg::b64e_job_t head_job
);
	import b64e_pkg::*;

	b64e_job_t            mem_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0]  wr_ptr_q;
	logic [QUEUE_AW-1:0]  rd_ptr_q;
	logic [QUEUE_AW:0]    count_q;

	logic do_push;
	logic do_pop;

	assign full       = (count_q == (QUEUE_AW+1)'(QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head_job   = mem_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	// Storage for queued groups.
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	// Pointers and occupancy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end
endmodule
`default_nettype wire

### hw/rtl/b64e_back.sv
`default_nettype none
module b64e_back (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                head_valid,
	input  wire b64e_pkg::b64e_job_t head_job,
	output logic               pop,
	output logic               out_valid,
	input  wire                out_ready,
	output logic [6:0]         out_char,
	output logic               out_run_last,
	output logic               out_stream_end
);
	import b64e_pkg::*;

	logic [2:0] slot_q;
	logic       valid_q;
	logic [6:0] char_q;
	logic       run_last_q;
	logic       stream_end_q;

	logic       load;
	logic       last_slot;
	logic       is_pad;
	logic [5:0] sextet;
	logic [6:0] next_char;

	// Output register takes a new character whenever it is empty or being drained.
	assign load      = head_valid && (!valid_q || out_ready);
	assign last_slot = head_job.newline ? (slot_q == SLOT_NEWLINE) : (slot_q == 3'd3);
	assign pop       = load && last_slot;

	// Pick the sextet for the current slot, most significant first.
	always_comb begin
		case (slot_q)
			3'd0:    sextet = head_job.group[23:18];
			3'd1:    sextet = head_job.group[17:12];
			3'd2:    sextet = head_job.group[11:6];
			default: sextet = head_job.group[5:0];
		endcase
	end

	// Decide between symbol, padding and newline.
	always_comb begin
		case (head_job.pad)
			PAD_ONE: is_pad = (slot_q == 3'd3);
			PAD_TWO: is_pad = (slot_q == 3'd2) || (slot_q == 3'd3);
			default: is_pad = 1'b0;
		endcase
		if (slot_q == SLOT_NEWLINE) begin
			next_char = CHAR_NEWLINE;
		end else if (is_pad) begin
			next_char = CHAR_PAD;
		end else begin
			next_char = b64e_symbol(sextet);
		end
	end

	// Slot counter within the current group.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= 3'd0;
		end else if (load) begin
			slot_q <= last_slot ? 3'd0 : slot_q + 3'd1;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			char_q       <= next_char;
			run_last_q   <= last_slot;
			stream_end_q <= last_slot && head_job.fin;
		end
	end

	assign out_valid      = valid_q;
	assign out_char       = char_q;
	assign out_run_last   = run_last_q;
	assign out_stream_end = stream_end_q;
endmodule
`default_nettype wire

### hw/rtl/b64e_checker.sv
`default_nettype none
module b64e_checker (
	input wire       clk,
	input wire       arst_n,
	input wire       out_valid,
	input wire       out_ready,
	input wire [6:0] out_char,
	input wire       out_run_last,
	input wire       out_stream_end
);
	import b64e_pkg::*;

	// A stalled character is held unchanged.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_char) &&
		$stable(out_run_last) && $stable(out_stream_end))
		else $error("stalled character changed");

	// A newline always closes the characters of its byte.
	a_newline_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_char == CHAR_NEWLINE) |-> out_run_last)
		else $error("newline not last of its byte");

	// The final pad character ends the whole encoding.
	a_pad_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_char == CHAR_PAD) && out_run_last |-> out_stream_end)
		else $error("trailing pad without stream end");

	// A pad that is not last is followed at once by another pad.
	a_pad_run: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && (out_char == CHAR_PAD) && !out_run_last |=>
		out_valid && (out_char == CHAR_PAD))
		else $error("pad run broken");
endmodule

bind base64_stream_encoder b64e_checker u_b64e_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.out_valid      (chars.valid),
	.out_ready      (chars.ready),
	.out_char       (chars.out_char),
	.out_run_last   (chars.run_last),
	.out_stream_end (chars.stream_end)
);
`default_nettype wire

### verif/base64_stream_encoder_tb.sv
`timescale 1ns / 100ps

module base64_stream_encoder_tb;
	import b64e_pkg::*;

	localparam int CYCLE_LIMIT      = 400000;
	localparam int SETTLE_CYCLES    = 8;
	localparam int RANDOM_PER_PHASE = 28;
	localparam int NUM_PHASES       = 9;
	localparam int NUM_ROWS         = 32;

	// One character as it leaves the encoder.
	typedef struct packed {
		logic [6:0] ch;
		logic       run_last;
		logic       stream_end;
	} b64_char_t;

	typedef enum logic {
		ROW_BYTE  = 1'b0,
		ROW_LIMIT = 1'b1
	} row_kind_t;

	// A row either writes the line limit or sends one byte. A non-empty text gives the
	// characters that the byte must produce; otherwise the encoding model decides.
	typedef struct {
		row_kind_t  kind;
		logic [9:0] value;
		logic       fin;
		string      typed;
	} stim_row_t;

	logic       clk;
	logic       arst_n;
	logic       cfg_we;
	logic [9:0] cfg_wdata;

	b64e_byte_if byte_ch ();
	b64e_char_if char_ch ();

	base64_stream_encoder i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.bytes     (byte_ch),
		.chars     (char_ch)
	);

	// Encoding model state.
	string       alphabet = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
	logic [9:0]  line_lim;
	logic [15:0] held_pair;
	logic [1:0]  held_n;
	logic [10:0] line_cnt;
	b64_char_t   fresh[0:4];
	int          fresh_n;

	b64_char_t   pending_chars[$];

	int fail_count;
	int cycle_count;
	int bytes_sent;
	int msgs_done;
	int chars_seen;
	int newlines_seen;
	int limits_written;
	int src_quiet;
	int sink_quiet;
	int sink_stall;
	int msg_left;

	stim_row_t directed_rows[0:NUM_ROWS-1] = '{
		'{ROW_LIMIT, 10'd0,    1'b0, ""},
		// Single byte with two pads, at both ends of the byte range.
		'{ROW_BYTE,  10'h000,  1'b1, "AA=="},
		'{ROW_BYTE,  10'h0ff,  1'b1, "/w=="},
		// Two bytes with one pad.
		'{ROW_BYTE,  10'h04d,  1'b0, ""},
		'{ROW_BYTE,  10'h061,  1'b1, "TWE="},
		// Full group on the final byte: no padding.
		'{ROW_BYTE,  10'h0ff,  1'b0, ""},
		'{ROW_BYTE,  10'h0ff,  1'b0, ""},
		'{ROW_BYTE,  10'h0ff,  1'b1, "////"},
		// Full group in the middle of a message.
		'{ROW_BYTE,  10'h04d,  1'b0, ""},
		'{ROW_BYTE,  10'h061,  1'b0, ""},
		'{ROW_BYTE,  10'h06e,  1'b0, "TWFu"},
		// Wrapping switched on mid-message; the counter already stands at four.
		'{ROW_LIMIT, 10'd4,    1'b0, ""},
		'{ROW_BYTE,  10'h0fb,  1'b0, ""},
		'{ROW_BYTE,  10'h0ef,  1'b0, ""},
		'{ROW_BYTE,  10'h0be,  1'b0, "++++\n"},
		'{ROW_BYTE,  10'h000,  1'b1, "AA=="},
		// Largest limit.
		'{ROW_LIMIT, 10'd1023, 1'b0, ""},
		'{ROW_BYTE,  10'h012,  1'b0, ""},
		'{ROW_BYTE,  10'h034,  1'b1, ""},
		// Smallest non-zero limit: the newline closes the message.
		'{ROW_LIMIT, 10'd1,    1'b0, ""},
		'{ROW_BYTE,  10'h001,  1'b0, ""},
		'{ROW_BYTE,  10'h002,  1'b0, ""},
		'{ROW_BYTE,  10'h003,  1'b1, ""},
		// Limit lowered part-way along a line.
		'{ROW_LIMIT, 10'd8,    1'b0, ""},
		'{ROW_BYTE,  10'h0a1,  1'b0, ""},
		'{ROW_BYTE,  10'h0b2,  1'b0, ""},
		'{ROW_BYTE,  10'h0c3,  1'b0, ""},
		'{ROW_LIMIT, 10'd4,    1'b0, ""},
		'{ROW_BYTE,  10'h007,  1'b0, ""},
		'{ROW_BYTE,  10'h018,  1'b0, ""},
		'{ROW_BYTE,  10'h029,  1'b0, ""},
		'{ROW_BYTE,  10'h03a,  1'b1, ""}
	};

	logic [9:0] phase_limits[0:NUM_PHASES-1] = '{
		10'd0, 10'd1, 10'd4, 10'd8, 10'd6, 10'd76, 10'd1023, 10'd2, 10'd0
	};

	always #2 clk = ~clk;

	// Idle length: mostly none or short, now and then long, with quiet stretches.
	function automatic int pick_gap(inout int quiet);
		int r;
		r = $urandom_range(0, 99);
		if (quiet > 0) begin
			quiet--;
			return 0;
		end
		if (r < 3) begin
			quiet = $urandom_range(20, 60);
			return 0;
		end
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(4, 25);
	endfunction

	function automatic logic [6:0] sextet_char(input logic [5:0] v);
		byte c;
		c = alphabet[v];
		return c[6:0];
	endfunction

	function automatic void add_char(input logic [6:0] c);
		fresh[fresh_n] = '{ch: c, run_last: 1'b0, stream_end: 1'b0};
		fresh_n++;
	endfunction

	// Characters caused by one byte; updates the held bytes and the line counter.
	function automatic void encode_byte(input logic [7:0] b, input logic fin);
		logic [23:0] grp;
		fresh_n = 0;
		if (held_n == 2'd2) begin
			grp = {held_pair, b};
			add_char(sextet_char(grp[23:18]));
			add_char(sextet_char(grp[17:12]));
			add_char(sextet_char(grp[11:6]));
			add_char(sextet_char(grp[5:0]));
			held_pair = '0;
			held_n    = '0;
			line_cnt  = line_cnt + 11'd4;
			if (line_lim != '0 && line_cnt >= {1'b0, line_lim}) begin
				add_char(CHAR_NEWLINE);
				line_cnt = '0;
			end
		end else if (fin) begin
			if (held_n == 2'd1) begin
				grp = {held_pair[7:0], b, 8'h00};
				add_char(sextet_char(grp[23:18]));
				add_char(sextet_char(grp[17:12]));
				add_char(sextet_char(grp[11:6]));
				add_char(CHAR_PAD);
			end else begin
				grp = {b, 16'h0000};
				add_char(sextet_char(grp[23:18]));
				add_char(sextet_char(grp[17:12]));
				add_char(CHAR_PAD);
				add_char(CHAR_PAD);
			end
		end else begin
			held_pair = {held_pair[7:0], b};
			held_n    = held_n + 2'd1;
			return;
		end
		fresh[fresh_n-1].run_last = 1'b1;
		if (fin) begin
			fresh[fresh_n-1].stream_end = 1'b1;
			held_pair = '0;
			held_n    = '0;
			line_cnt  = '0;
		end
	endfunction

	// Record what an accepted byte must produce.
	function automatic void queue_expected(input logic [7:0] b, input logic fin,
		input string typed);
		byte c;
		logic tail;
		encode_byte(b, fin);
		bytes_sent++;
		if (fin)
			msgs_done++;
		if (typed.len() != 0) begin
			for (int i = 0; i < typed.len(); i++) begin
				c    = typed[i];
				tail = (i == typed.len() - 1);
				pending_chars.push_back('{ch: c[6:0], run_last: tail,
					stream_end: tail & fin});
			end
		end else begin
			for (int i = 0; i < fresh_n; i++)
				pending_chars.push_back(fresh[i]);
		end
	endfunction

	task automatic send_byte(input logic [7:0] b, input logic fin, input string typed);
		int gap;
		gap = pick_gap(src_quiet);
		if (gap > 0) begin
			byte_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		byte_ch.valid      <= 1'b1;
		byte_ch.data_byte  <= b;
		byte_ch.final_byte <= fin;
		do @(posedge clk); while (!byte_ch.ready);
		queue_expected(b, fin, typed);
	endtask

	// The limit is only changed once the encoder has drained.
	task automatic write_limit(input logic [9:0] lim);
		byte_ch.valid <= 1'b0;
		while (pending_chars.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= lim;
		@(posedge clk);
		cfg_we   <= 1'b0;
		line_lim = lim;
		limits_written++;
	endtask

	// Random message length: mostly short, some long enough for several lines.
	function automatic int pick_msg_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return $urandom_range(1, 9);
		if (r < 92)
			return $urandom_range(10, 30);
		return $urandom_range(31, 72);
	endfunction

	// Character sink with random back-pressure.
	always @(posedge clk) begin
		if (sink_stall > 0) begin
			char_ch.ready <= 1'b0;
			sink_stall--;
		end else begin
			char_ch.ready <= 1'b1;
			sink_stall = pick_gap(sink_quiet);
		end
	end

	// Compare every character transaction with the oldest expectation.
	always @(posedge clk) begin
		b64_char_t got;
		b64_char_t want;
		if (arst_n && char_ch.valid && char_ch.ready) begin
			got = '{ch: char_ch.out_char, run_last: char_ch.run_last,
				stream_end: char_ch.stream_end};
			chars_seen++;
			if (got.ch == CHAR_NEWLINE)
				newlines_seen++;
			if (pending_chars.size() == 0) begin
				fail_count++;
				if (fail_count <= 10)
					$display("Unexpected character %02h last %0b end %0b at cycle %0d.",
						got.ch, got.run_last, got.stream_end, cycle_count);
			end else begin
				want = pending_chars.pop_front();
				if (got !== want) begin
					fail_count++;
					if (fail_count <= 10)
						$display("Mismatch at cycle %0d: want %02h/%0b/%0b, got %02h/%0b/%0b.",
							cycle_count, want.ch, want.run_last, want.stream_end,
							got.ch, got.run_last, got.stream_end);
				end
			end
		end
	end

	// Watchdog.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timed out with %0d characters outstanding.", pending_chars.size());
			$display("base64_stream_encoder_tb: errors");
			$finish;
		end
	end

	initial begin
		logic [9:0] lim;
		int         len;
		clk                = 1'b0;
		arst_n             = 1'b0;
		cfg_we             = 1'b0;
		cfg_wdata          = '0;
		byte_ch.valid      = 1'b0;
		byte_ch.data_byte  = '0;
		byte_ch.final_byte = 1'b0;
		char_ch.ready      = 1'b0;
		line_lim  = '0;
		held_pair = '0;
		held_n    = '0;
		line_cnt  = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table.
		for (int i = 0; i < NUM_ROWS; i++) begin
			if (directed_rows[i].kind == ROW_LIMIT)
				write_limit(directed_rows[i].value);
			else
				send_byte(directed_rows[i].value[7:0], directed_rows[i].fin,
					directed_rows[i].typed);
		end

		// Random messages under a sequence of line limits. A message may run across
		// a change of limit, so the counter carries over into the new setting.
		msg_left = 0;
		for (int p = 0; p < NUM_PHASES; p++) begin
			lim = phase_limits[p];
			if (p == NUM_PHASES - 1)
				lim = 10'($urandom_range(2, 40));
			write_limit(lim);
			for (int k = 0; k < RANDOM_PER_PHASE; k++) begin
				if (msg_left == 0) begin
					len      = pick_msg_len();
					msg_left = len;
				end
				send_byte(8'($urandom_range(0, 255)), msg_left == 1, "");
				msg_left--;
			end
		end
		// Close any message still open.
		if (msg_left > 0) begin
			while (msg_left > 0) begin
				send_byte(8'($urandom_range(0, 255)), msg_left == 1, "");
				msg_left--;
			end
		end

		byte_ch.valid <= 1'b0;
		while (pending_chars.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Sent %0d bytes in %0d messages; checked %0d characters, %0d newlines.",
			bytes_sent, msgs_done, chars_seen, newlines_seen);
		$display("Line limit written %0d times, from 0 up to 1023; %0d failures.",
			limits_written, fail_count);
		if (fail_count == 0)
			$display("base64_stream_encoder_tb: clean");
		else
			$display("base64_stream_encoder_tb: errors");
		$finish;
	end

endmodule

### sim.f
hw/rtl/b64e_pkg.sv
hw/rtl/b64e_if.sv
hw/rtl/b64e_front.sv
hw/rtl/b64e_queue.sv
hw/rtl/b64e_back.sv
hw/rtl/base64_stream_encoder.sv
hw/rtl/b64e_checker.sv
verif/base64_stream_encoder_tb.sv
